// ===== hdl/sds_pkg.sv =====
// shared types, constants and the control program of the spring damper smoother
package sds_pkg;

    localparam int GAIN_W    = 16;
    localparam int ACC_W     = 64;
    localparam int PC_W      = 5;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_STIFFNESS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DAMPING     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CUBIC       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INV_MASS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_STEP = 3'd4;

    localparam logic CMD_SET_TARGET = 1'b0;
    localparam logic CMD_TICK       = 1'b1;

    localparam logic [GAIN_W-1:0] STIFFNESS_RST = 16'd25600;
    localparam logic [GAIN_W-1:0] DAMPING_RST   = 16'd2560;
    localparam logic [GAIN_W-1:0] CUBIC_RST     = 16'd0;
    localparam logic [GAIN_W-1:0] INV_MASS_RST  = 16'd256;
    localparam int                DEFAULT_STEP_RST = 1092;

    // step where the spring product starts; the cubic term is skipped up to here
    localparam logic [PC_W-1:0] PC_SPRING = 5'd8;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_INIT,
        OP_COPY_E,
        OP_MUL,
        OP_SHIFT_F,
        OP_SUM_T,
        OP_SHIFT_8,
        OP_FORCE,
        OP_ACCEL,
        OP_VEL,
        OP_POS
    } t_op;

    typedef enum logic [1:0] {
        XS_E,
        XS_W,
        XS_V
    } t_xsel;

    typedef enum logic [2:0] {
        YS_E,
        YS_CUBIC,
        YS_STIFF,
        YS_DAMP,
        YS_INV,
        YS_DT
    } t_ysel;

    typedef enum logic [1:0] {
        NX_SEQ,
        NX_WAIT,
        NX_JUMP_CZ,
        NX_END
    } t_next;

    typedef enum logic {
        SQ_IDLE,
        SQ_RUN
    } t_seq_state;

    typedef struct packed {
        t_op              op;
        t_xsel            xsel;
        t_ysel            ysel;
        t_next            nxt;
        logic [PC_W-1:0]  jmp;
    } t_uword;

    typedef struct packed {
        logic mul_done;
        logic cubic_zero;
    } t_dp_status;

    typedef struct packed {
        logic [GAIN_W-1:0] stiffness;
        logic [GAIN_W-1:0] damping;
        logic [GAIN_W-1:0] cubic;
        logic [GAIN_W-1:0] inv_mass;
    } t_gains;

    // control program of one tick
    function automatic t_uword sds_rom(input logic [PC_W-1:0] pc);
        t_uword w;
        w = '{OP_NOP, XS_E, YS_E, NX_END, PC_W'(0)};
        case (pc)
            5'd0:  w = '{OP_INIT,    XS_E, YS_E,     NX_SEQ,     PC_W'(0)};
            5'd1:  w = '{OP_COPY_E,  XS_E, YS_E,     NX_JUMP_CZ, PC_SPRING};
            5'd2:  w = '{OP_MUL,     XS_E, YS_E,     NX_WAIT,    PC_W'(0)};
            5'd3:  w = '{OP_SHIFT_F, XS_E, YS_E,     NX_SEQ,     PC_W'(0)};
            5'd4:  w = '{OP_MUL,     XS_W, YS_E,     NX_WAIT,    PC_W'(0)};
            5'd5:  w = '{OP_SHIFT_F, XS_E, YS_E,     NX_SEQ,     PC_W'(0)};
            5'd6:  w = '{OP_MUL,     XS_W, YS_CUBIC, NX_WAIT,    PC_W'(0)};
            5'd7:  w = '{OP_SUM_T,   XS_E, YS_E,     NX_SEQ,     PC_W'(0)};
            5'd8:  w = '{OP_MUL,     XS_W, YS_STIFF, NX_WAIT,    PC_W'(0)};
            5'd9:  w = '{OP_SHIFT_8, XS_E, YS_E,     NX_SEQ,     PC_W'(0)};
            5'd10: w = '{OP_MUL,     XS_V, YS_DAMP,  NX_WAIT,    PC_W'(0)};
            5'd11: w = '{OP_FORCE,   XS_E, YS_E,     NX_SEQ,     PC_W'(0)};
            5'd12: w = '{OP_MUL,     XS_W, YS_INV,   NX_WAIT,    PC_W'(0)};
            5'd13: w = '{OP_ACCEL,   XS_E, YS_E,     NX_SEQ,     PC_W'(0)};
            5'd14: w = '{OP_MUL,     XS_W, YS_DT,    NX_WAIT,    PC_W'(0)};
            5'd15: w = '{OP_VEL,     XS_E, YS_E,     NX_SEQ,     PC_W'(0)};
            5'd16: w = '{OP_MUL,     XS_V, YS_DT,    NX_WAIT,    PC_W'(0)};
            5'd17: w = '{OP_POS,     XS_E, YS_E,     NX_END,     PC_W'(0)};
            default: w = '{OP_NOP,   XS_E, YS_E,     NX_END,     PC_W'(0)};
        endcase
        return w;
    endfunction

endpackage

// ===== hdl/sds_mac.sv =====
// digit-serial multiply-accumulate: 16-bit digits of x against a full y
module sds_mac #(
    parameter int XW = 48,
    parameter int YW = 22
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_run,
    input  logic signed [XW-1:0]             i_x,
    input  logic signed [YW-1:0]             i_y,
    output logic signed [sds_pkg::ACC_W-1:0] o_acc,
    output logic                             o_done
);
    import sds_pkg::*;

    localparam int ND = (XW + 15) / 16;
    localparam int IW = (ND > 1) ? $clog2(ND) : 1;

    logic                    r_busy;
    logic signed [XW-1:0]    r_mx;
    logic [IW-1:0]           r_idx;
    logic signed [ACC_W-1:0] r_acc;

    logic signed [XW-1:0]    x_cur;
    logic [IW-1:0]           idx;
    logic signed [ACC_W-1:0] base;
    logic                    fits;
    logic signed [16:0]      digit;
    logic signed [16+YW:0]   prod;
    logic signed [ACC_W-1:0] part;

    always_comb begin
        x_cur = r_busy ? r_mx : i_x;
        idx   = r_busy ? r_idx : '0;
        base  = r_busy ? r_acc : '0;
        // top digit is taken signed once the rest is pure sign
        fits  = (&x_cur[XW-1:16]) | ~(|x_cur[XW-1:16]);
        digit = fits ? x_cur[16:0] : {1'b0, x_cur[15:0]};
        prod  = digit * i_y;
        part  = ACC_W'(prod) <<< {idx, 4'b0000};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= i_run & ~fits;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_run) begin
            r_acc <= base + part;
            r_mx  <= x_cur >>> 16;
            r_idx <= idx + 1'b1;
        end
    end

    assign o_acc  = r_acc;
    assign o_done = i_run & fits;

endmodule

// ===== hdl/sds_datapath.sv =====
// state registers, operand selection, adder with clamp and the shared multiplier
module sds_datapath #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sds_pkg::t_uword               i_uw,
    input  sds_pkg::t_gains               i_gains,
    input  logic [FRACTION_BITS:0]        i_default_step,
    input  logic                          i_load_target,
    input  logic signed [FRACTION_BITS+1:0] i_target_value,
    input  logic                          i_load_step,
    input  logic [FRACTION_BITS:0]        i_step_time,
    output logic [FRACTION_BITS+3:0]      o_position,
    output sds_pkg::t_dp_status           o_status
);
    import sds_pkg::*;

    localparam int F   = FRACTION_BITS;
    localparam int PW  = F + 4;
    localparam int VW  = F + 8;
    localparam int EW  = F + 6;
    localparam int YW  = (F + 6 > GAIN_W + 1) ? F + 6 : GAIN_W + 1;
    localparam int XWA = (F + 30 > 62 - F) ? F + 30 : 62 - F;
    localparam int XW  = (XWA > 48) ? XWA : 48;

    localparam logic signed [ACC_W-1:0] FORCE_HI = ACC_W'(1) <<< 46;
    localparam logic signed [ACC_W-1:0] FORCE_LO = -FORCE_HI;
    localparam logic signed [ACC_W-1:0] ACCEL_HI = ACC_W'(1) <<< (60 - F);
    localparam logic signed [ACC_W-1:0] ACCEL_LO = -ACCEL_HI;
    localparam logic signed [ACC_W-1:0] VEL_HI   = (ACC_W'(1) <<< (VW - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] VEL_LO   = -(ACC_W'(1) <<< (VW - 1));
    localparam logic signed [ACC_W-1:0] POS_HI   = (ACC_W'(1) <<< PW) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] POS_LO   = '0;

    logic [F:0]            r_target;
    logic [PW-1:0]         r_pos;
    logic signed [VW-1:0]  r_vel;
    logic signed [EW-1:0]  r_e;
    logic signed [XW-1:0]  r_w;
    logic [F:0]            r_dt;

    logic signed [XW-1:0]    mul_x;
    logic signed [YW-1:0]    mul_y;
    logic signed [ACC_W-1:0] acc;
    logic                    mul_done;
    logic signed [ACC_W-1:0] acc8;
    logic signed [ACC_W-1:0] accf;
    logic signed [ACC_W-1:0] a_op;
    logic signed [ACC_W-1:0] b_op;
    logic signed [ACC_W-1:0] lo;
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] sum;
    logic signed [ACC_W-1:0] res;
    logic                    sub;
    logic                    clamp_en;
    logic [F:0]              target_clamped;
    logic                    step_ok;

    // operand selection for the multiplier
    always_comb begin
        case (i_uw.xsel)
            XS_E:    mul_x = XW'(r_e);
            XS_W:    mul_x = r_w;
            XS_V:    mul_x = XW'(r_vel);
            default: mul_x = r_w;
        endcase
        case (i_uw.ysel)
            YS_E:     mul_y = YW'(r_e);
            YS_CUBIC: mul_y = YW'($signed({1'b0, i_gains.cubic}));
            YS_STIFF: mul_y = YW'($signed({1'b0, i_gains.stiffness}));
            YS_DAMP:  mul_y = YW'($signed({1'b0, i_gains.damping}));
            YS_INV:   mul_y = YW'($signed({1'b0, i_gains.inv_mass}));
            YS_DT:    mul_y = YW'($signed({1'b0, r_dt}));
            default:  mul_y = '0;
        endcase
    end

    sds_mac #(
        .XW (XW),
        .YW (YW)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_run   (i_uw.op == OP_MUL),
        .i_x     (mul_x),
        .i_y     (mul_y),
        .o_acc   (acc),
        .o_done  (mul_done)
    );

    // adder with optional clamp behind the product
    always_comb begin
        acc8     = acc >>> 8;
        accf     = acc >>> F;
        a_op     = '0;
        b_op     = '0;
        sub      = 1'b0;
        clamp_en = 1'b0;
        lo       = POS_LO;
        hi       = POS_HI;
        case (i_uw.op)
            OP_COPY_E: a_op = ACC_W'(r_e);
            OP_SHIFT_F: b_op = accf;
            OP_SUM_T: begin
                a_op = ACC_W'(r_e);
                b_op = acc8;
            end
            OP_SHIFT_8: b_op = acc8;
            OP_FORCE: begin
                a_op     = ACC_W'(r_w);
                b_op     = acc8;
                sub      = 1'b1;
                clamp_en = 1'b1;
                lo       = FORCE_LO;
                hi       = FORCE_HI;
            end
            OP_ACCEL: begin
                b_op     = acc8;
                clamp_en = 1'b1;
                lo       = ACCEL_LO;
                hi       = ACCEL_HI;
            end
            OP_VEL: begin
                a_op     = ACC_W'(r_vel);
                b_op     = accf;
                clamp_en = 1'b1;
                lo       = VEL_LO;
                hi       = VEL_HI;
            end
            OP_POS: begin
                a_op     = ACC_W'($signed({1'b0, r_pos}));
                b_op     = accf;
                clamp_en = 1'b1;
            end
            default: ;
        endcase
        sum = sub ? a_op - b_op : a_op + b_op;
        if (clamp_en && sum < lo) begin
            res = lo;
        end else if (clamp_en && sum > hi) begin
            res = hi;
        end else begin
            res = sum;
        end
    end

    // target clamp to 0..1.0 and time step check
    always_comb begin
        if (i_target_value[F+1]) begin
            target_clamped = '0;
        end else if (i_target_value[F] && |i_target_value[F-1:0]) begin
            target_clamped = {1'b1, {F{1'b0}}};
        end else begin
            target_clamped = i_target_value[F:0];
        end
        step_ok = (|i_step_time) && !(i_step_time[F] && |i_step_time[F-1:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= '0;
            r_pos    <= '0;
            r_vel    <= '0;
        end else begin
            if (i_load_target) begin
                r_target <= target_clamped;
            end
            if (i_uw.op == OP_VEL) begin
                r_vel <= VW'(res);
            end
            if (i_uw.op == OP_POS) begin
                r_pos <= PW'(res);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load_step) begin
            r_dt <= step_ok ? i_step_time : i_default_step;
        end
        if (i_uw.op == OP_INIT) begin
            r_e <= $signed({5'b0, r_target}) - $signed({2'b0, r_pos});
        end
        case (i_uw.op)
            OP_COPY_E, OP_SHIFT_F, OP_SUM_T, OP_SHIFT_8, OP_FORCE, OP_ACCEL: begin
                r_w <= XW'(res);
            end
            default: ;
        endcase
    end

    assign o_position        = r_pos;
    assign o_status.mul_done   = mul_done;
    assign o_status.cubic_zero = (i_gains.cubic == '0);

endmodule

// ===== hdl/sds_sequencer.sv =====
// step counter and jump logic walking the control program
module sds_sequencer (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_out_free,
    input  sds_pkg::t_dp_status  i_status,
    output sds_pkg::t_uword      o_uw,
    output logic                 o_idle,
    output logic                 o_result
);
    import sds_pkg::*;

    t_seq_state       r_state;
    t_seq_state       n_state;
    logic [PC_W-1:0]  r_pc;
    logic [PC_W-1:0]  n_pc;
    t_uword           uw;
    logic             fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SQ_IDLE;
            r_pc    <= '0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
        end
    end

    always_comb begin
        uw       = sds_rom(r_pc);
        n_state  = r_state;
        n_pc     = r_pc;
        fire     = 1'b0;
        o_idle   = 1'b0;
        o_result = 1'b0;
        case (r_state)
            SQ_IDLE: begin
                o_idle = 1'b1;
                if (i_start) begin
                    n_state = SQ_RUN;
                    n_pc    = '0;
                end
            end
            SQ_RUN: begin
                case (uw.nxt)
                    NX_SEQ: begin
                        fire = 1'b1;
                        n_pc = r_pc + 1'b1;
                    end
                    NX_WAIT: begin
                        fire = 1'b1;
                        if (i_status.mul_done) begin
                            n_pc = r_pc + 1'b1;
                        end
                    end
                    NX_JUMP_CZ: begin
                        fire = 1'b1;
                        n_pc = i_status.cubic_zero ? uw.jmp : r_pc + 1'b1;
                    end
                    NX_END: begin
                        // hold the last step until the output slot is free
                        if (i_out_free) begin
                            fire     = 1'b1;
                            o_result = 1'b1;
                            n_state  = SQ_IDLE;
                        end
                    end
                    default: n_state = SQ_IDLE;
                endcase
            end
            default: n_state = SQ_IDLE;
        endcase
        o_uw = uw;
        if (!fire) begin
            o_uw.op = OP_NOP;
        end
    end

endmodule

// ===== hdl/spring_damper_smoother_unit.sv =====
// top level of the spring damper smoother: stream ports, config registers, result slot
//
// Eases a position toward a target with a fixed-point mass-spring-damper.
// Input stream: tuser[0] is the command (0 = set target, 1 = tick), tdata
// carries target_value and step_time. A set-target request is taken and gives
// no result. A tick request runs a short control program on one shared
// digit-serial multiplier and returns the new position on the output
// stream.
// The time a tick takes grows with its plain program steps and with the
// 16-bit digits the multiplier's digit loop consumes; with a zero cubic
// weight the cubic steps are skipped. One tick is worked on at a time; the
// next request is taken only after it ends.
// A finished position sits in the output slot while the next request is
// taken; if the receiver stalls, the next tick holds on its last step until
// the slot is read.
// Config port: ready only while no tick runs, ahead of a waiting request;
// unknown indexes are dropped.
// Reset (synchronous, active low) clears target, position and velocity, loads
// the default gains and holds both ready outputs low.
module spring_damper_smoother_unit #(
    parameter int FRACTION_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,

    // slave side: tdata = target_value [F+1:0], step_time [2F+2:F+2], zero pad
    input  logic                                        s_axis_tvalid,
    output logic                                        s_axis_tready,
    input  logic [((2*FRACTION_BITS+10)/8)*8-1:0]        s_axis_tdata,
    // tuser = command
    input  logic [0:0]                                  s_axis_tuser,

    // master side: tdata = position_out [F+3:0], zero pad
    output logic                                        m_axis_tvalid,
    input  logic                                        m_axis_tready,
    output logic [((FRACTION_BITS+11)/8)*8-1:0]          m_axis_tdata,

    // configuration writes
    input  logic                                        i_cfg_valid,
    output logic                                        o_cfg_ready,
    input  logic [sds_pkg::CFG_IDX_W-1:0]               i_cfg_index,
    input  logic [((FRACTION_BITS + 1 > sds_pkg::GAIN_W) ?
                   FRACTION_BITS + 1 : sds_pkg::GAIN_W)-1:0] i_cfg_data
);
    import sds_pkg::*;

    localparam int F     = FRACTION_BITS;
    localparam int OUT_W = ((F + 11) / 8) * 8;

    t_gains          r_gains;
    logic [F:0]      r_default_step;
    logic            r_out_valid;

    logic            in_accept;
    logic            cfg_write;
    logic            load_target;
    logic            load_step;
    logic            seq_idle;
    logic            seq_result;
    logic            out_free;
    t_uword          uw;
    t_dp_status      dp_status;
    logic [F+3:0]    position;

    // requests are taken whenever no tick is running and no config write waits
    assign s_axis_tready = i_rst_n & seq_idle & ~i_cfg_valid;
    assign in_accept     = s_axis_tvalid & s_axis_tready;
    assign load_target   = in_accept & (s_axis_tuser[0] == CMD_SET_TARGET);
    assign load_step     = in_accept & (s_axis_tuser[0] == CMD_TICK);

    // config registers, written only between ticks
    assign o_cfg_ready = i_rst_n & seq_idle;
    assign cfg_write   = i_cfg_valid & o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gains.stiffness <= STIFFNESS_RST;
            r_gains.damping   <= DAMPING_RST;
            r_gains.cubic     <= CUBIC_RST;
            r_gains.inv_mass  <= INV_MASS_RST;
            r_default_step    <= (F + 1)'(DEFAULT_STEP_RST);
        end else if (cfg_write) begin
            case (i_cfg_index)
                REG_STIFFNESS:    r_gains.stiffness <= i_cfg_data[GAIN_W-1:0];
                REG_DAMPING:      r_gains.damping   <= i_cfg_data[GAIN_W-1:0];
                REG_CUBIC:        r_gains.cubic     <= i_cfg_data[GAIN_W-1:0];
                REG_INV_MASS:     r_gains.inv_mass  <= i_cfg_data[GAIN_W-1:0];
                REG_DEFAULT_STEP: r_default_step    <= i_cfg_data[F:0];
                default: ;
            endcase
        end
    end

    // output slot: position register holds the data, this flag the valid
    assign out_free = ~r_out_valid | m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (seq_result) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    sds_sequencer u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (load_step),
        .i_out_free (out_free),
        .i_status   (dp_status),
        .o_uw       (uw),
        .o_idle     (seq_idle),
        .o_result   (seq_result)
    );

    sds_datapath #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_uw           (uw),
        .i_gains        (r_gains),
        .i_default_step (r_default_step),
        .i_load_target  (load_target),
        .i_target_value (s_axis_tdata[F+1:0]),
        .i_load_step    (load_step),
        .i_step_time    (s_axis_tdata[2*F+2:F+2]),
        .o_position     (position),
        .o_status       (dp_status)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_W'(position);

endmodule
